>>> hdl/line_junction_classifier_top_defines.svh
// Assertion macros used by the port-level checker of the line junction classifier.
`ifndef LINE_JUNCTION_CLASSIFIER_TOP_DEFINES_SVH
`define LINE_JUNCTION_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LJC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LJC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hdl/ljc_pkg.sv
// Types, constants and helper functions of the line junction classifier.
`timescale 1ns / 1ps
package ljc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned WIDTH_BITS = 4;
  localparam int unsigned LIMIT_BITS = 7;
  localparam int unsigned ERROR_BITS = 8;
  localparam int unsigned MAG_BITS   = ERROR_BITS;
  localparam int unsigned IN_BITS    = 24;
  localparam int unsigned OUT_BITS   = 8;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = LIMIT_BITS;

  localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RST  = 4'd2;
  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RST  = 4'd4;
  localparam logic [WIDTH_BITS-1:0] WIDE_WIDTH_RST = 4'd5;
  localparam logic [LIMIT_BITS-1:0] ERR_LIMIT_RST  = 7'd9;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN_WIDTH  = 2'd0,
    CFG_MAX_WIDTH  = 2'd1,
    CFG_WIDE_WIDTH = 2'd2,
    CFG_ERR_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    JCT_NONE   = 3'd0,
    JCT_LEFT_L = 3'd1,
    JCT_RIGHT_L = 3'd2,
    JCT_LEFT_T = 3'd3,
    JCT_RIGHT_T = 3'd4,
    JCT_PLUS   = 3'd5,
    JCT_TWOWAY = 3'd6
  } junction_e;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] min_width;
    logic [WIDTH_BITS-1:0] max_width;
    logic [WIDTH_BITS-1:0] wide_width;
    logic [LIMIT_BITS-1:0] err_limit;
  } cfg_t;

  typedef struct packed {
    logic                        left_seen;
    logic                        right_seen;
    logic [COUNT_BITS-1:0]       left_length;
    logic [COUNT_BITS-1:0]       right_length;
    logic [COUNT_BITS-1:0]       ahead_confidence;
  } track_t;

  typedef struct packed {
    logic                        all_blank;
    logic                        single_line;
    logic [WIDTH_BITS-1:0]       line_width;
    logic                        outer_left;
    logic                        outer_right;
    logic                        middle_hit;
    logic signed [ERROR_BITS-1:0] line_error;
  } frame_t;

  typedef struct packed {
    junction_e junction;
    logic      line_end;
  } result_t;

  // Junction type from the latched branch flags. A lone left branch with the
  // line continuing ahead is reported as a right T, and the mirror likewise.
  function automatic junction_e decide_code(input logic left_seen,
                                            input logic right_seen,
                                            input logic ahead);
    junction_e code;
    code = JCT_NONE;
    if (left_seen && !right_seen) begin
      code = ahead ? JCT_RIGHT_T : JCT_LEFT_L;
    end else if (!left_seen && right_seen) begin
      code = ahead ? JCT_LEFT_T : JCT_RIGHT_L;
    end else if (left_seen && right_seen) begin
      code = ahead ? JCT_PLUS : JCT_TWOWAY;
    end
    return code;
  endfunction

endpackage

>>> hdl/ljc_step.sv
// Next tracking state and result for one sensor frame.
`timescale 1ns / 1ps
module ljc_step
  import ljc_pkg::*;
(
  input  cfg_t    cfg_i,
  input  track_t  track_i,
  input  frame_t  frame_i,
  output track_t  track_o,
  output result_t result_o
);

  logic [MAG_BITS-1:0]   err_mag;
  logic                  clean_line;
  logic [COUNT_BITS-1:0] bound;
  track_t                trk;
  result_t               res;

  assign err_mag = frame_i.line_error[ERROR_BITS-1] ? MAG_BITS'(-frame_i.line_error)
                                                    : MAG_BITS'(frame_i.line_error);

  assign clean_line = frame_i.single_line
                    && (frame_i.line_width <= cfg_i.max_width)
                    && (frame_i.line_width >= cfg_i.min_width)
                    && !frame_i.outer_left && !frame_i.outer_right;

  always_comb begin
    trk          = track_i;
    res.junction = JCT_NONE;
    res.line_end = 1'b0;
    bound        = '0;

    // A blank frame closes an open junction with no line ahead.
    if (frame_i.all_blank && (trk.left_seen || trk.right_seen)) begin
      res.junction         = decide_code(trk.left_seen, trk.right_seen, 1'b0);
      trk.left_seen        = 1'b0;
      trk.right_seen       = 1'b0;
      trk.left_length      = '0;
      trk.right_length     = '0;
      trk.ahead_confidence = '0;
    end

    // Enough clean forward frames past the branch length close it with a line ahead.
    if (clean_line && (trk.left_seen || trk.right_seen)) begin
      bound = trk.left_seen ? trk.left_length : trk.right_length;
      if (trk.ahead_confidence < bound) begin
        trk.ahead_confidence = trk.ahead_confidence + COUNT_BITS'(1);
      end else begin
        res.junction         = decide_code(trk.left_seen, trk.right_seen, 1'b1);
        trk.left_seen        = 1'b0;
        trk.right_seen       = 1'b0;
        trk.left_length      = '0;
        trk.right_length     = '0;
        trk.ahead_confidence = '0;
      end
    end

    if ((frame_i.line_width > cfg_i.wide_width) && frame_i.middle_hit) begin
      if (frame_i.outer_left) begin
        trk.left_seen = 1'b1;
      end
      if (frame_i.outer_right) begin
        trk.right_seen = 1'b1;
      end
    end
    if (frame_i.outer_left && frame_i.outer_right) begin
      trk.left_seen  = 1'b1;
      trk.right_seen = 1'b1;
    end

    if (trk.left_seen && frame_i.outer_left) begin
      trk.left_length = trk.left_length + COUNT_BITS'(1);
    end
    if (trk.right_seen && frame_i.outer_right) begin
      trk.right_length = trk.right_length + COUNT_BITS'(1);
    end

    if (frame_i.all_blank && (err_mag < MAG_BITS'(cfg_i.err_limit))
        && !trk.left_seen && !trk.right_seen) begin
      res.line_end     = 1'b1;
      trk.left_length  = '0;
      trk.right_length = '0;
    end

    track_o  = trk;
    result_o = res;
  end

endmodule

>>> hdl/line_junction_classifier_top.sv
// Top level of the line junction classifier: stream ports, registers and pipeline.
// An accepted request waits in the frame register until the result register is
// free; its result then loads there and is on the output port. Throughput: one
// frame per cycle unless the output stalls; the tracking state is updated in the
// same cycle the result register loads. Reset clears the tracking state, both
// valid flags and the configuration to its defaults (2, 4, 5 and 9).
`timescale 1ns / 1ps
module line_junction_classifier_top
  import ljc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // all_blank, single_line, line_width[3:0], outer_left, outer_right,
  // middle_hit, line_error[7:0], zero padding
  input  logic [IN_BITS-1:0]       s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // junction[2:0], line_end, zero padding
  output logic [OUT_BITS-1:0]      m_axis_tdata_o
);

  cfg_t    cfg_q;
  track_t  track_q, track_d;
  frame_t  frame_q, frame_in;
  result_t res_q, res_d;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;

  assign frame_in.all_blank   = s_axis_tdata_i[0];
  assign frame_in.single_line = s_axis_tdata_i[1];
  assign frame_in.line_width  = s_axis_tdata_i[5:2];
  assign frame_in.outer_left  = s_axis_tdata_i[6];
  assign frame_in.outer_right = s_axis_tdata_i[7];
  assign frame_in.middle_hit  = s_axis_tdata_i[8];
  assign frame_in.line_error  = s_axis_tdata_i[16:9];

  // The step fires when a frame is held and the result register is free.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width  <= MIN_WIDTH_RST;
      cfg_q.max_width  <= MAX_WIDTH_RST;
      cfg_q.wide_width <= WIDE_WIDTH_RST;
      cfg_q.err_limit  <= ERR_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_WIDTH:  cfg_q.min_width  <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_MAX_WIDTH:  cfg_q.max_width  <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_WIDE_WIDTH: cfg_q.wide_width <= cfg_data_i[WIDTH_BITS-1:0];
        CFG_ERR_LIMIT:  cfg_q.err_limit  <= cfg_data_i[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  ljc_step u_step (
    .cfg_i    (cfg_q),
    .track_i  (track_q),
    .frame_i  (frame_q),
    .track_o  (track_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      track_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        track_q     <= track_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      frame_q <= frame_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.line_end, res_q.junction};

endmodule

>>> hdl/ljc_checker.sv
// Port-level checker for the line junction classifier, bound to the top level.
`timescale 1ns / 1ps
`include "line_junction_classifier_top_defines.svh"
module ljc_checker
  import ljc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [OUT_BITS-1:0]      m_axis_tdata_o
);

  logic                  out_stall;
  logic [OUT_BITS-5:0]   out_pad;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_pad   = m_axis_tdata_o[OUT_BITS-1:4];

  // Input back-pressure only arises when both stages are full and the output is stalled.
  `LJC_ASSERT_IMPL(a_stall_means_full, clk_i, rst_ni, !s_axis_tready_o, out_stall)

  // Padding bits of a result request are always zero.
  `LJC_ASSERT_IMPL(a_out_padding, clk_i, rst_ni, m_axis_tvalid_o, out_pad == '0)

  `LJC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  `LJC_ASSERT_IMPL(a_out_drop, clk_i, rst_ni, $fell(m_axis_tvalid_o), $past(m_axis_tready_i))

endmodule

bind line_junction_classifier_top ljc_checker u_ljc_checker (.*);

>>> test/ljc_frame_checker.sv
// Checker for the line junction classifier: predicts each frame's result and compares it.
`timescale 1ns / 1ps
module ljc_frame_checker
  import ljc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     s_tvalid_i,
  input  logic                     s_tready_i,
  input  logic [IN_BITS-1:0]       s_tdata_i,
  input  logic                     m_tvalid_i,
  input  logic                     m_tready_i,
  input  logic [OUT_BITS-1:0]      m_tdata_i,
  output int unsigned              mismatch_cnt_o,
  output int unsigned              waiting_cnt_o
);

  logic [WIDTH_BITS-1:0] min_w;
  logic [WIDTH_BITS-1:0] max_w;
  logic [WIDTH_BITS-1:0] wide_w;
  logic [LIMIT_BITS-1:0] err_lim;

  logic                  left_flag;
  logic                  right_flag;
  logic [COUNT_BITS-1:0] left_len;
  logic [COUNT_BITS-1:0] right_len;
  logic [COUNT_BITS-1:0] fwd_conf;

  result_t expected_results[$];
  result_t want;

  initial begin
    mismatch_cnt_o = 0;
    waiting_cnt_o  = 0;
  end

  function automatic void drop_branches();
    left_flag  = 1'b0;
    right_flag = 1'b0;
    left_len   = '0;
    right_len  = '0;
  endfunction

  // Type of the junction being left, from the latched flags; the flags and
  // branch counts are cleared as part of the decision.
  function automatic junction_e close_junction(input logic ahead);
    junction_e code;
    unique case ({left_flag, right_flag})
      2'b10:   code = ahead ? JCT_RIGHT_T : JCT_LEFT_L;
      2'b01:   code = ahead ? JCT_LEFT_T : JCT_RIGHT_L;
      2'b11:   code = ahead ? JCT_PLUS : JCT_TWOWAY;
      default: code = JCT_NONE;
    endcase
    drop_branches();
    return code;
  endfunction

  function automatic result_t classify_frame(input logic [IN_BITS-1:0] d);
    logic                  blank;
    logic                  single;
    logic [WIDTH_BITS-1:0] width;
    logic                  ol;
    logic                  orr;
    logic                  mid;
    logic [ERROR_BITS-1:0] err;
    logic [ERROR_BITS-1:0] mag;
    logic [COUNT_BITS-1:0] bound;
    result_t               res;
    blank  = d[0];
    single = d[1];
    width  = d[5:2];
    ol     = d[6];
    orr    = d[7];
    mid    = d[8];
    err    = d[16:9];
    // Magnitude of -128 comes out as 128, which an 8-bit unsigned holds.
    mag    = err[ERROR_BITS-1] ? (~err + 1'b1) : err;
    res.junction = JCT_NONE;
    res.line_end = 1'b0;

    if (blank && (left_flag || right_flag)) begin
      res.junction = close_junction(1'b0);
      fwd_conf     = '0;
    end

    if (single && width <= max_w && width >= min_w && !ol && !orr
        && (left_flag || right_flag)) begin
      bound = left_flag ? left_len : right_len;
      if (fwd_conf < bound) begin
        fwd_conf = fwd_conf + 1'b1;
      end else begin
        res.junction = close_junction(1'b1);
        fwd_conf     = '0;
      end
    end

    if (width > wide_w && mid) begin
      if (ol) left_flag = 1'b1;
      if (orr) right_flag = 1'b1;
    end
    if (ol && orr) begin
      left_flag  = 1'b1;
      right_flag = 1'b1;
    end

    if (left_flag && ol) left_len = left_len + 1'b1;
    if (right_flag && orr) right_len = right_len + 1'b1;

    if (blank && mag < {1'b0, err_lim} && !left_flag && !right_flag) begin
      res.line_end = 1'b1;
      drop_branches();
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_w    = MIN_WIDTH_RST;
      max_w    = MAX_WIDTH_RST;
      wide_w   = WIDE_WIDTH_RST;
      err_lim  = ERR_LIMIT_RST;
      drop_branches();
      fwd_conf = '0;
      expected_results.delete();
      waiting_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_WIDTH:  min_w   = cfg_data_i[WIDTH_BITS-1:0];
          CFG_MAX_WIDTH:  max_w   = cfg_data_i[WIDTH_BITS-1:0];
          CFG_WIDE_WIDTH: wide_w  = cfg_data_i[WIDTH_BITS-1:0];
          CFG_ERR_LIMIT:  err_lim = cfg_data_i[LIMIT_BITS-1:0];
          default: ;
        endcase
      end

      // Results are checked before this edge's request is predicted, so a
      // result can never be matched against a frame taken at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result %h arrived with no frame waiting for one", $time, m_tdata_i);
          mismatch_cnt_o++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata_i[2:0] !== want.junction || m_tdata_i[3] !== want.line_end
              || m_tdata_i[OUT_BITS-1:4] !== '0) begin
            $display({"%0t: expected junction %0d line_end %0d, ",
                      "got junction %0d line_end %0d (data %h)"},
                     $time, want.junction, want.line_end, m_tdata_i[2:0], m_tdata_i[3],
                     m_tdata_i);
            mismatch_cnt_o++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) expected_results.push_back(classify_frame(s_tdata_i));
      waiting_cnt_o = expected_results.size();
    end
  end

endmodule

>>> test/tb.sv
// Testbench top for the line junction classifier: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import ljc_pkg::*;

  localparam int unsigned PHASE_FRAMES = 150;
  localparam int unsigned PHASES       = 8;

  logic                     clk_i;
  logic                     rst_ni   = 1'b0;
  logic                     cfg_we   = 1'b0;
  cfg_idx_e                 cfg_idx  = CFG_MIN_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_valid  = 1'b0;
  logic                     s_ready;
  logic [IN_BITS-1:0]       s_data   = '0;
  logic                     m_valid;
  logic                     m_ready  = 1'b0;
  logic [OUT_BITS-1:0]      m_data;
  logic                     frame_taken = 1'b0;

  int unsigned mismatch_cnt;
  int unsigned waiting_cnt;
  int unsigned frames_sent = 0;
  int unsigned calm_left   = 0;
  int unsigned ready_hold  = 0;
  int unsigned ready_roll;

  // Software copy of the registers, used only to shape the stimulus.
  logic [WIDTH_BITS-1:0] cur_min  = MIN_WIDTH_RST;
  logic [WIDTH_BITS-1:0] cur_max  = MAX_WIDTH_RST;
  logic [WIDTH_BITS-1:0] cur_wide = WIDE_WIDTH_RST;
  logic [LIMIT_BITS-1:0] cur_lim  = ERR_LIMIT_RST;

  line_junction_classifier_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  ljc_frame_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_tvalid_i     (s_valid),
    .s_tready_i     (s_ready),
    .s_tdata_i      (s_data),
    .m_tvalid_i     (m_valid),
    .m_tready_i     (m_ready),
    .m_tdata_i      (m_data),
    .mismatch_cnt_o (mismatch_cnt),
    .waiting_cnt_o  (waiting_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) frame_taken <= s_valid && s_ready;

  // Output back-pressure: mostly short stalls, a few long ones, and now and
  // then a stretch of steady readiness.
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 4) begin
        m_ready <= 1'b1;
        ready_hold = $urandom_range(10, 60);
      end else if (ready_roll < 55) begin
        m_ready <= 1'b1;
      end else if (ready_roll < 90) begin
        m_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else if (ready_roll < 97) begin
        m_ready <= 1'b0;
        ready_hold = $urandom_range(3, 9);
      end else begin
        m_ready <= 1'b0;
        ready_hold = $urandom_range(20, 40);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [IN_BITS-1:0] pack_frame(input logic blank, input logic single,
                                                    input logic [WIDTH_BITS-1:0] width,
                                                    input logic ol, input logic orr,
                                                    input logic mid,
                                                    input logic [ERROR_BITS-1:0] err);
    return {{(IN_BITS-17){1'b0}}, err, mid, orr, ol, width, single, blank};
  endfunction

  function automatic logic [IN_BITS-1:0] noise_frame();
    logic [16:0] bits;
    bits = 17'($urandom);
    return {{(IN_BITS-17){1'b0}}, bits};
  endfunction

  // A clean single forward line: the width sits inside the accepted band
  // whenever the band is not empty.
  function automatic logic [IN_BITS-1:0] clean_frame();
    logic [WIDTH_BITS-1:0] width;
    logic [ERROR_BITS-1:0] err;
    if (cur_min <= cur_max) width = WIDTH_BITS'($urandom_range(cur_min, cur_max));
    else width = WIDTH_BITS'($urandom_range(0, 15));
    err = ERROR_BITS'($urandom_range(0, 40));
    err = err - 8'd20;
    return pack_frame(1'b0, 1'b1, width, 1'b0, 1'b0, 1'($urandom_range(0, 1)), err);
  endfunction

  // Blank frame with the error mostly near the line-end limit.
  function automatic logic [IN_BITS-1:0] blank_frame();
    logic [ERROR_BITS-1:0] err;
    logic [WIDTH_BITS-1:0] width;
    if ($urandom_range(0, 1) == 0) begin
      err = ERROR_BITS'($urandom_range(0, cur_lim + 1));
      if ($urandom_range(0, 1) == 0) err = ~err + 1'b1;
    end else begin
      err = ERROR_BITS'($urandom);
    end
    width = ($urandom_range(0, 3) == 0) ? WIDTH_BITS'($urandom_range(0, 15)) : '0;
    return pack_frame(1'b1, $urandom_range(0, 9) == 0, width,
                      $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0,
                      1'($urandom_range(0, 1)), err);
  endfunction

  // Frame that latches a branch: 0 left, 1 right, 2 both (a lone side only below a wide width of 15).
  function automatic logic [IN_BITS-1:0] latch_frame(input int unsigned side);
    logic [WIDTH_BITS-1:0] width;
    if (side == 2 && $urandom_range(0, 1) == 0) begin
      return pack_frame(1'b0, 1'($urandom_range(0, 1)), WIDTH_BITS'($urandom_range(0, 15)),
                        1'b1, 1'b1, 1'($urandom_range(0, 1)), ERROR_BITS'($urandom));
    end
    width = (cur_wide == 4'd15) ? 4'd15 : WIDTH_BITS'($urandom_range(cur_wide + 1, 15));
    return pack_frame(1'b0, $urandom_range(0, 7) == 0, width, side != 1, side != 0, 1'b1,
                      ERROR_BITS'($urandom));
  endfunction

  // The branch is still in view, so its length count grows.
  function automatic logic [IN_BITS-1:0] branch_frame(input int unsigned side);
    return pack_frame(1'b0, 1'b0, WIDTH_BITS'($urandom_range(0, 15)), side != 1, side != 0,
                      1'($urandom_range(0, 1)), ERROR_BITS'($urandom));
  endfunction

  // Entered and left at a falling edge; the valid stays high on return so that
  // back-to-back requests need only one assignment per edge.
  task automatic send_frame(input logic [IN_BITS-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    @(negedge clk_i);
    while (!frame_taken) @(negedge clk_i);
    frames_sent++;
  endtask

  task automatic emit(input logic [IN_BITS-1:0] data);
    if ($urandom_range(0, 9) == 0) send_frame(noise_frame());
    send_frame(data);
  endtask

  task automatic run_junction();
    int unsigned side;
    int unsigned arms;
    side = $urandom_range(0, 2);
    arms = $urandom_range(0, 5);
    repeat ($urandom_range(0, 3)) emit(clean_frame());
    emit(latch_frame(side));
    repeat (arms) emit(branch_frame(side));
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, arms + 4)) emit(clean_frame());
    end else begin
      emit(blank_frame());
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (waiting_cnt != 0);
  endtask

  task automatic program_regs(input logic [WIDTH_BITS-1:0] min_w,
                              input logic [WIDTH_BITS-1:0] max_w,
                              input logic [WIDTH_BITS-1:0] wide_w,
                              input logic [LIMIT_BITS-1:0] lim);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MIN_WIDTH;
    cfg_data <= CFG_DATA_BITS'(min_w);
    @(negedge clk_i);
    cfg_idx  <= CFG_MAX_WIDTH;
    cfg_data <= CFG_DATA_BITS'(max_w);
    @(negedge clk_i);
    cfg_idx  <= CFG_WIDE_WIDTH;
    cfg_data <= CFG_DATA_BITS'(wide_w);
    @(negedge clk_i);
    cfg_idx  <= CFG_ERR_LIMIT;
    cfg_data <= lim;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cur_min  = min_w;
    cur_max  = max_w;
    cur_wide = wide_w;
    cur_lim  = lim;
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned roll;
    logic [WIDTH_BITS-1:0] lo;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames on the reset settings: every junction type, both
    // line-end outcomes and the error extremes.
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h80));  // -128
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h7F));
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'hF7));  // -9, not below
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h08));
    send_frame(pack_frame(1'b0, 1'b1, 4'd3, 1'b0, 1'b0, 1'b1, 8'h00));  // no branch held
    send_frame(pack_frame(1'b0, 1'b0, 4'd6, 1'b1, 1'b0, 1'b1, 8'h10));
    send_frame(pack_frame(1'b0, 1'b1, 4'd2, 1'b0, 1'b0, 1'b0, 8'h01));
    send_frame(pack_frame(1'b0, 1'b1, 4'd4, 1'b0, 1'b0, 1'b1, 8'hFF));
    send_frame(pack_frame(1'b0, 1'b0, 4'd6, 1'b0, 1'b1, 1'b1, 8'h00));
    send_frame(pack_frame(1'b0, 1'b1, 4'd3, 1'b0, 1'b0, 1'b0, 8'h00));
    send_frame(pack_frame(1'b0, 1'b1, 4'd3, 1'b0, 1'b0, 1'b0, 8'h00));
    send_frame(pack_frame(1'b0, 1'b0, 4'd15, 1'b1, 1'b1, 1'b1, 8'h7F));
    // Blank and single together: the blank decision wins and line end follows.
    send_frame(pack_frame(1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_frame(pack_frame(1'b0, 1'b0, 4'd6, 1'b1, 1'b0, 1'b1, 8'h00));
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'h64));
    send_frame(pack_frame(1'b0, 1'b0, 4'd6, 1'b0, 1'b1, 1'b1, 8'h00));
    send_frame(pack_frame(1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 8'hFB));  // -5
    // Both outer sensors latch both branches even on a narrow frame.
    send_frame(pack_frame(1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 1'b0, 8'h00));
    send_frame(pack_frame(1'b0, 1'b1, 4'd3, 1'b0, 1'b0, 1'b0, 8'h00));
    send_frame(pack_frame(1'b0, 1'b1, 4'd3, 1'b0, 1'b0, 1'b0, 8'h00));
    send_frame(pack_frame(1'b0, 1'b1, 4'd15, 1'b0, 1'b0, 1'b1, 8'h00));
    drain();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0: program_regs(MIN_WIDTH_RST, MAX_WIDTH_RST, WIDE_WIDTH_RST, ERR_LIMIT_RST);
        1: program_regs(4'd0, 4'd0, 4'd0, 7'd0);
        2: program_regs(4'd15, 4'd15, 4'd15, 7'd127);
        // Band with its minimum above its maximum: no clean forward line.
        3: program_regs(4'd9, 4'd3, WIDTH_BITS'($urandom_range(0, 14)),
                        LIMIT_BITS'($urandom_range(0, 127)));
        4: program_regs(4'd0, 4'd15, 4'd0, 7'd127);
        default: begin
          lo = WIDTH_BITS'($urandom_range(0, 5));
          program_regs(lo, WIDTH_BITS'($urandom_range(lo, 15)),
                       WIDTH_BITS'($urandom_range(0, 14)),
                       LIMIT_BITS'($urandom_range(0, 127)));
        end
      endcase
      phase_end = frames_sent + PHASE_FRAMES;
      while (frames_sent < phase_end) begin
        roll = $urandom_range(0, 9);
        if (roll < 8) run_junction();
        else if (roll < 9) send_frame(blank_frame());
        else send_frame(noise_frame());
      end
      drain();
    end

    repeat (6) @(negedge clk_i);
    if (mismatch_cnt == 0 && waiting_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ljc_pkg.sv
hdl/ljc_step.sv
hdl/line_junction_classifier_top.sv
hdl/ljc_checker.sv
test/ljc_frame_checker.sv
test/tb.sv
